>>> rtl/cp1610_instruction_decoder_core_macros.svh
// Assertion macros for the CP1610 instruction decoder core.
// No dependencies; included by the top level.
`ifndef CP1610_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define CP1610_INSTRUCTION_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define CPDEC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define CPDEC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CPDEC_ASSERT(label, clk, rst_n, prop, msg)
`define CPDEC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/cpdec_pkg.sv
// Types, codes and sizes shared by the CP1610 instruction decoder files.
// No dependencies.
package cpdec_pkg;

	// default queue depths
	localparam int CPDEC_QUEUE_DEPTH  = 2;
	localparam int CPDEC_RESULT_DEPTH = 2;

	// operand kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_REG  = 3'd1;
	localparam logic [2:0] KIND_ADDR = 3'd2;
	localparam logic [2:0] KIND_IMM  = 3'd3;
	localparam logic [2:0] KIND_LIT2 = 3'd4;
	localparam logic [2:0] KIND_LITE = 3'd5;

	// mnemonic codes (first of each group)
	localparam logic [6:0] MN_HLT      = 7'd0;
	localparam logic [6:0] MN_SDBD     = 7'd1;
	localparam logic [6:0] MN_EIS      = 7'd2;
	localparam logic [6:0] MN_DIS      = 7'd3;
	localparam logic [6:0] MN_J        = 7'd4;
	localparam logic [6:0] MN_JSR      = 7'd8;
	localparam logic [6:0] MN_TCI      = 7'd12;
	localparam logic [6:0] MN_CLRC     = 7'd13;
	localparam logic [6:0] MN_SETC     = 7'd14;
	localparam logic [6:0] MN_GSWD     = 7'd20;
	localparam logic [6:0] MN_NOP      = 7'd21;
	localparam logic [6:0] MN_SIN      = 7'd22;
	localparam logic [6:0] MN_RSWD     = 7'd23;
	localparam logic [6:0] MN_SWAP     = 7'd24;
	localparam logic [6:0] MN_TSTR     = 7'd32;
	localparam logic [6:0] MN_JR       = 7'd33;
	localparam logic [6:0] MN_MOVR     = 7'd34;
	localparam logic [6:0] MN_CLRR     = 7'd39;
	localparam logic [6:0] MN_XORR     = 7'd40;
	localparam logic [6:0] MN_B        = 7'd41;
	localparam logic [6:0] MN_NOPP     = 7'd42;
	localparam logic [6:0] MN_BCOND    = 7'd43;
	localparam logic [6:0] MN_BEXT     = 7'd59;
	localparam logic [6:0] MN_MVO      = 7'd60;
	localparam logic [6:0] MN_PSHR     = 7'd61;
	localparam logic [6:0] MN_MVOI     = 7'd62;
	localparam logic [6:0] MN_MVO_IND  = 7'd63;
	localparam logic [6:0] MN_MVI      = 7'd64;
	localparam logic [6:0] MN_PULR     = 7'd65;
	localparam logic [6:0] MN_ALU_BASE = 7'd68;

	// where an operand value comes from
	typedef enum logic [3:0] {
		SRC_NONE,
		SRC_REG2,
		SRC_REG3,
		SRC_REG3LO,
		SRC_LINK,
		SRC_JADDR,
		SRC_BADDR,
		SRC_WORD2,
		SRC_IMM,
		SRC_LIT2,
		SRC_LITE
	} src_t;

	// where the target comes from
	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_JADDR,
		TGT_BADDR
	} tgt_t;

	// input request
	typedef struct packed {
		logic [15:0] instr_addr;
		logic        double_byte;
		logic [9:0]  word_one;
		logic [15:0] word_two;
		logic [15:0] word_three;
	} cpdec_req_t;

	// classified instruction, front to back
	typedef struct packed {
		cpdec_req_t  req;
		logic [1:0]  word_count;
		logic [6:0]  mnemonic_code;
		logic [2:0]  first_kind;
		src_t        first_src;
		logic [2:0]  second_kind;
		src_t        second_src;
		tgt_t        tgt_sel;
	} cpdec_cls_t;

	// result
	typedef struct packed {
		logic [1:0]  word_count;
		logic [6:0]  mnemonic_code;
		logic [2:0]  first_kind;
		logic [15:0] first_value;
		logic [2:0]  second_kind;
		logic [15:0] second_value;
		logic [15:0] target_addr;
		logic        target_valid;
	} cpdec_rsp_t;

endpackage

>>> rtl/cpdec_fifo.sv
// Small synchronous queue of generic entries.
// Used between decoder stages and on the result side; no package needed.
module cpdec_fifo #(
	parameter int DEPTH = 2,
	parameter type entry_t = logic
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  entry_t wdata,
	output logic   empty,
	input  logic   pop,
	output entry_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/cpdec_front.sv
// Front end: classifies an instruction into length, mnemonic and operand sources.
// Depends on cpdec_pkg.
module cpdec_front
	import cpdec_pkg::*;
(
	input  cpdec_req_t instr,
	output cpdec_cls_t cls
);

	// implied-operand mnemonics by low opcode bits
	function automatic logic [6:0] implied_code(input logic [2:0] sel);
		logic [6:0] code;
		case (sel)
			3'd0:    code = MN_HLT;
			3'd1:    code = MN_SDBD;
			3'd2:    code = MN_EIS;
			3'd3:    code = MN_DIS;
			3'd5:    code = MN_TCI;
			3'd6:    code = MN_CLRC;
			3'd7:    code = MN_SETC;
			default: code = MN_HLT;
		endcase
		return code;
	endfunction

	// instruction length
	function automatic logic [1:0] count_words(input logic [9:0] op, input logic dbd);
		logic [1:0] n;
		if (op == 10'h004)                    n = 2'd3;
		else if ((op & 10'h3c0) == 10'h200)   n = 2'd2;
		else if ((op & 10'h3f8) == 10'h240)   n = 2'd2;
		else if ((op & 10'h3f8) == 10'h278)   n = 2'd2;
		else if ((op & 10'h238) == 10'h200)   n = 2'd2;
		else if ((op & 10'h238) == 10'h238)   n = dbd ? 2'd3 : 2'd2;
		else                                  n = 2'd1;
		return n;
	endfunction

	logic [3:0] i1;
	logic [2:0] i2;
	logic [2:0] i3;
	logic [9:0] w1;
	logic       is_mvi;
	logic [6:0] alu_base;

	assign w1       = instr.word_one;
	assign i1       = w1[9:6];
	assign i2       = w1[5:3];
	assign i3       = w1[2:0];
	assign is_mvi   = (i1 == 4'd10);
	assign alu_base = is_mvi ? MN_MVI : 7'(int'(MN_ALU_BASE) + 3 * (int'(i1) - 11));

	// opcode decode
	always_comb begin
		cls               = '0;
		cls.req           = instr;
		cls.word_count    = count_words(w1, instr.double_byte);
		cls.mnemonic_code = MN_HLT;
		cls.first_kind    = KIND_NONE;
		cls.first_src     = SRC_NONE;
		cls.second_kind   = KIND_NONE;
		cls.second_src    = SRC_NONE;
		cls.tgt_sel       = TGT_NONE;
		unique case (i1)
			4'd0: begin
				if (i2 == 3'd0) begin
					if (i3 == 3'd4) begin
						cls.tgt_sel = TGT_JADDR;
						if (instr.word_two[9:8] == 2'b11) begin
							cls.mnemonic_code = MN_J + 7'(instr.word_two[1:0]);
							cls.first_kind    = KIND_ADDR;
							cls.first_src     = SRC_JADDR;
						end else begin
							cls.mnemonic_code = MN_JSR + 7'(instr.word_two[1:0]);
							cls.first_kind    = KIND_REG;
							cls.first_src     = SRC_LINK;
							cls.second_kind   = KIND_ADDR;
							cls.second_src    = SRC_JADDR;
						end
					end else begin
						cls.mnemonic_code = implied_code(i3);
					end
				end else if (i2 == 3'd6) begin
					if (!i3[2]) begin
						cls.mnemonic_code = MN_GSWD;
						cls.first_kind    = KIND_REG;
						cls.first_src     = SRC_REG3LO;
					end else begin
						cls.mnemonic_code = i3[1] ? MN_SIN : MN_NOP;
						if (i3[0]) begin
							cls.first_kind = KIND_LIT2;
							cls.first_src  = SRC_LIT2;
						end
					end
				end else if (i2 == 3'd7) begin
					cls.mnemonic_code = MN_RSWD;
					cls.first_kind    = KIND_REG;
					cls.first_src     = SRC_REG3;
				end else begin
					// INCR through ADCR
					cls.mnemonic_code = MN_SETC + 7'(i2);
					cls.first_kind    = KIND_REG;
					cls.first_src     = SRC_REG3;
				end
			end
			4'd1: begin
				cls.mnemonic_code = MN_SWAP + 7'(i2);
				cls.first_kind    = KIND_REG;
				cls.first_src     = SRC_REG3LO;
				if (i3[2]) begin
					cls.second_kind = KIND_LIT2;
					cls.second_src  = SRC_LIT2;
				end
			end
			4'd2: begin
				cls.first_kind = KIND_REG;
				cls.first_src  = SRC_REG2;
				if (i2 == i3) begin
					cls.mnemonic_code = MN_TSTR;
				end else if (i3 == 3'd7) begin
					cls.mnemonic_code = MN_JR;
				end else begin
					cls.mnemonic_code = MN_MOVR;
					cls.second_kind   = KIND_REG;
					cls.second_src    = SRC_REG3;
				end
			end
			4'd3, 4'd4, 4'd5, 4'd6: begin
				cls.mnemonic_code = MN_TSTR + 7'(i1);
				cls.first_kind    = KIND_REG;
				cls.first_src     = SRC_REG2;
				cls.second_kind   = KIND_REG;
				cls.second_src    = SRC_REG3;
			end
			4'd7: begin
				if (i2 == i3) begin
					cls.mnemonic_code = MN_CLRR;
					cls.first_kind    = KIND_REG;
					cls.first_src     = SRC_REG3;
				end else begin
					cls.mnemonic_code = MN_XORR;
					cls.first_kind    = KIND_REG;
					cls.first_src     = SRC_REG2;
					cls.second_kind   = KIND_REG;
					cls.second_src    = SRC_REG3;
				end
			end
			4'd8: begin
				if (w1[4:0] == 5'h08) begin
					cls.mnemonic_code = MN_NOPP;
				end else begin
					if (w1[4:0] == 5'h00) begin
						cls.mnemonic_code = MN_B;
					end else if (!w1[4]) begin
						cls.mnemonic_code = MN_BCOND + 7'(w1[3:0]);
					end else begin
						cls.mnemonic_code = MN_BEXT;
						cls.second_kind   = KIND_LITE;
						cls.second_src    = SRC_LITE;
					end
					cls.first_kind = KIND_ADDR;
					cls.first_src  = SRC_BADDR;
					cls.tgt_sel    = TGT_BADDR;
				end
			end
			4'd9: begin
				cls.first_kind = KIND_REG;
				cls.first_src  = SRC_REG3;
				if (i2 == 3'd0) begin
					cls.mnemonic_code = MN_MVO;
					cls.second_kind   = KIND_ADDR;
					cls.second_src    = SRC_WORD2;
				end else if (i2 == 3'd6) begin
					cls.mnemonic_code = MN_PSHR;
				end else if (i2 == 3'd7) begin
					cls.mnemonic_code = MN_MVOI;
					cls.second_kind   = KIND_IMM;
					cls.second_src    = SRC_IMM;
				end else begin
					cls.mnemonic_code = MN_MVO_IND;
					cls.second_kind   = KIND_REG;
					cls.second_src    = SRC_REG2;
				end
			end
			default: begin
				// MVI and the two-operand memory ALU forms
				if (is_mvi && i2 == 3'd6) begin
					cls.mnemonic_code = MN_PULR;
					cls.first_kind    = KIND_REG;
					cls.first_src     = SRC_REG3;
				end else begin
					if (i2 == 3'd0) begin
						cls.mnemonic_code = alu_base;
						cls.first_kind    = KIND_ADDR;
						cls.first_src     = SRC_WORD2;
					end else if (i2 == 3'd7) begin
						cls.mnemonic_code = alu_base + (is_mvi ? 7'd2 : 7'd1);
						cls.first_kind    = KIND_IMM;
						cls.first_src     = SRC_IMM;
					end else begin
						cls.mnemonic_code = alu_base + (is_mvi ? 7'd3 : 7'd2);
						cls.first_kind    = KIND_REG;
						cls.first_src     = SRC_REG2;
					end
					cls.second_kind = KIND_REG;
					cls.second_src  = SRC_REG3;
				end
			end
		endcase
	end

endmodule

>>> rtl/cpdec_back.sv
// Back end: forms operand values and the jump or branch target.
// Depends on cpdec_pkg.
module cpdec_back
	import cpdec_pkg::*;
(
	input  cpdec_cls_t cls,
	output cpdec_rsp_t rsp
);

	logic [15:0] reg2;
	logic [15:0] reg3;
	logic [15:0] reg3lo;
	logic [15:0] link;
	logic [15:0] jaddr;
	logic [15:0] baddr;
	logic [15:0] imm;

	// value sources
	assign reg2   = {13'd0, cls.req.word_one[5:3]};
	assign reg3   = {13'd0, cls.req.word_one[2:0]};
	assign reg3lo = {14'd0, cls.req.word_one[1:0]};
	assign link   = {13'd0, 1'b1, cls.req.word_two[9:8]};
	assign jaddr  = {cls.req.word_two[7:2], cls.req.word_three[9:0]};
	assign imm    = cls.req.double_byte ?
		{cls.req.word_three[7:0], cls.req.word_two[7:0]} : cls.req.word_two;

	// branch displacement, direction from opcode bit 5
	assign baddr = cls.req.word_one[5] ?
		(cls.req.instr_addr + 16'd1 - cls.req.word_two) :
		(cls.req.instr_addr + 16'd2 + cls.req.word_two);

	function automatic logic [15:0] pick(
		input src_t        sel,
		input logic [15:0] r2,
		input logic [15:0] r3,
		input logic [15:0] r3lo,
		input logic [15:0] lnk,
		input logic [15:0] ja,
		input logic [15:0] ba,
		input logic [15:0] w2,
		input logic [15:0] im
	);
		logic [15:0] v;
		unique case (sel)
			SRC_NONE:   v = 16'd0;
			SRC_REG2:   v = r2;
			SRC_REG3:   v = r3;
			SRC_REG3LO: v = r3lo;
			SRC_LINK:   v = lnk;
			SRC_JADDR:  v = ja;
			SRC_BADDR:  v = ba;
			SRC_WORD2:  v = w2;
			SRC_IMM:    v = im;
			SRC_LIT2:   v = 16'd2;
			SRC_LITE:   v = 16'd14;
			default:    v = 16'd0;
		endcase
		return v;
	endfunction

	// result assembly
	always_comb begin
		rsp               = '0;
		rsp.word_count    = cls.word_count;
		rsp.mnemonic_code = cls.mnemonic_code;
		rsp.first_kind    = cls.first_kind;
		rsp.first_value   = pick(cls.first_src, reg2, reg3, reg3lo, link, jaddr, baddr,
			cls.req.word_two, imm);
		rsp.second_kind   = cls.second_kind;
		rsp.second_value  = pick(cls.second_src, reg2, reg3, reg3lo, link, jaddr, baddr,
			cls.req.word_two, imm);
		unique case (cls.tgt_sel)
			TGT_NONE: begin
				rsp.target_addr  = 16'd0;
				rsp.target_valid = 1'b0;
			end
			TGT_JADDR: begin
				rsp.target_addr  = jaddr;
				rsp.target_valid = 1'b1;
			end
			TGT_BADDR: begin
				rsp.target_addr  = baddr;
				rsp.target_valid = 1'b1;
			end
			default: begin
				rsp.target_addr  = 16'd0;
				rsp.target_valid = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/cp1610_instruction_decoder_core.sv
// CP1610 instruction decoder, top level: front decode, queue, back end, result queue.
// Depends on cpdec_pkg, cpdec_front, cpdec_fifo, cpdec_back and the macros header.
//
//  channel   handshake       payload
//  input     push / full     instr  (cpdec_req_t)
//  result    pop / empty     result (cpdec_rsp_t)
//
// One instruction per cycle sustained while results are popped; a taken request
// is written into the decode queue and moves into the result queue once that
// queue has room, where its result is on the result ports and can be popped.
// Reset clears only queue pointers and counts; queued payload is not reset.
// A stalled result side fills the result queue, then the decode queue, and
// full rises; throughput is set by the one-entry-per-cycle queue ports.
`include "cp1610_instruction_decoder_core_macros.svh"

module cp1610_instruction_decoder_core
	import cpdec_pkg::*;
#(
	parameter int QUEUE_DEPTH  = CPDEC_QUEUE_DEPTH,
	parameter int RESULT_DEPTH = CPDEC_RESULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  cpdec_req_t instr,
	output logic       empty,
	input  logic       pop,
	output cpdec_rsp_t result
);

	cpdec_cls_t cls_front;
	cpdec_cls_t cls_back;
	cpdec_rsp_t rsp_back;
	logic       mid_empty;
	logic       mid_full;
	logic       res_full;
	logic       advance;

	// front decode
	cpdec_front u_front (
		.instr (instr),
		.cls   (cls_front)
	);

	assign full = mid_full;

	// queue between front and back
	cpdec_fifo #(
		.DEPTH   (QUEUE_DEPTH),
		.entry_t (cpdec_cls_t)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (mid_full),
		.wdata  (cls_front),
		.empty  (mid_empty),
		.pop    (advance),
		.rdata  (cls_back)
	);

	// back end moves one request whenever the decode queue holds one and the result queue has room
	assign advance = !mid_empty && !res_full;

	cpdec_back u_back (
		.cls (cls_back),
		.rsp (rsp_back)
	);

	// result queue
	cpdec_fifo #(
		.DEPTH   (RESULT_DEPTH),
		.entry_t (cpdec_rsp_t)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.full   (res_full),
		.wdata  (rsp_back),
		.empty  (empty),
		.pop    (pop),
		.rdata  (result)
	);

	// checks
	`CPDEC_ASSERT(a_push_lands, clk, arst_n, (push && !full) |=> !mid_empty, "accepted request missing from decode queue")
	`CPDEC_ASSERT_NEVER(a_len_zero, clk, arst_n, !empty && result.word_count == 2'd0, "zero-length result")
	`CPDEC_ASSERT(a_tgt_clear, clk, arst_n, (!empty && !result.target_valid) |-> result.target_addr == 16'd0, "target without valid flag")
	`CPDEC_ASSERT(a_none_zero, clk, arst_n, (!empty && result.first_kind == KIND_NONE) |-> result.first_value == 16'd0, "value on missing operand")

endmodule

>>> test/tb_cp1610_instruction_decoder_core.sv
// Self-checking testbench for the CP1610 instruction decoder core.
// Needs cpdec_pkg and the core; a built-in decode predictor checks every result.
module tb_cp1610_instruction_decoder_core;
	import cpdec_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;

	// a request together with the decode it must produce
	typedef struct {
		cpdec_req_t req;
		cpdec_rsp_t rsp;
	} decode_pair_t;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       push   = 1'b0;
	logic       pop    = 1'b0;
	cpdec_req_t instr  = '0;
	logic       full;
	logic       empty;
	cpdec_rsp_t result;

	cpdec_req_t   pending_instr_q[$];
	decode_pair_t expected_decode_q[$];
	decode_pair_t oldest;

	int errors         = 0;
	int sent_count     = 0;
	int decoded_count  = 0;
	int target_count   = 0;
	int sdbd_count     = 0;
	int directed_count = 0;
	int send_wait      = 0;
	int recv_wait      = 0;
	int idle_cycles    = 0;

	always #5 clk = ~clk;

	cp1610_instruction_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.instr  (instr),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// expected decode of one instruction
	function automatic cpdec_rsp_t decode_instr(input cpdec_req_t r);
		cpdec_rsp_t  o;
		logic [9:0]  w1;
		logic [15:0] w2;
		logic [15:0] w3;
		logic [15:0] imm;
		logic [15:0] jaddr;
		logic [15:0] baddr;
		logic [3:0]  i1;
		logic [2:0]  i2;
		logic [2:0]  i3;
		logic [6:0]  base;
		o  = '0;
		w1 = r.word_one;
		w2 = r.word_two;
		w3 = r.word_three;
		i1 = w1[9:6];
		i2 = w1[5:3];
		i3 = w1[2:0];
		imm   = r.double_byte ? {w3[7:0], w2[7:0]} : w2;
		jaddr = 16'((w2 & 16'h00fc) << 8) + (w3 & 16'h03ff);
		baddr = i2[2] ? (r.instr_addr + 16'd1 - w2) : (r.instr_addr + 16'd2 + w2);

		// length in words
		if (w1 == 10'h004)
			o.word_count = 2'd3;
		else if ((w1 & 10'h3c0) == 10'h200 || (w1 & 10'h3f8) == 10'h240 ||
				(w1 & 10'h3f8) == 10'h278 || (w1 & 10'h238) == 10'h200)
			o.word_count = 2'd2;
		else if ((w1 & 10'h238) == 10'h238)
			o.word_count = r.double_byte ? 2'd3 : 2'd2;
		else
			o.word_count = 2'd1;

		case (i1)
			4'd0: begin
				if (i2 == 3'd0) begin
					if (i3 == 3'd4) begin
						o.target_valid = 1'b1;
						o.target_addr  = jaddr;
						if (w2[9:8] == 2'b11) begin
							// plain jump, no link register
							o.mnemonic_code = MN_J + 7'(w2[1:0]);
							o.first_kind    = KIND_ADDR;
							o.first_value   = jaddr;
						end else begin
							o.mnemonic_code = MN_JSR + 7'(w2[1:0]);
							o.first_kind    = KIND_REG;
							o.first_value   = 16'd4 + 16'(w2[9:8]);
							o.second_kind   = KIND_ADDR;
							o.second_value  = jaddr;
						end
					end else begin
						case (i3)
							3'd1: o.mnemonic_code = MN_SDBD;
							3'd2: o.mnemonic_code = MN_EIS;
							3'd3: o.mnemonic_code = MN_DIS;
							3'd5: o.mnemonic_code = MN_TCI;
							3'd6: o.mnemonic_code = MN_CLRC;
							3'd7: o.mnemonic_code = MN_SETC;
							default: o.mnemonic_code = MN_HLT;
						endcase
					end
				end else if (i2 == 3'd6) begin
					if (i3 < 3'd4) begin
						o.mnemonic_code = MN_GSWD;
						o.first_kind    = KIND_REG;
						o.first_value   = 16'(i3[1:0]);
					end else begin
						o.mnemonic_code = (i3 < 3'd6) ? MN_NOP : MN_SIN;
						if (i3[0]) begin
							o.first_kind  = KIND_LIT2;
							o.first_value = 16'd2;
						end
					end
				end else if (i2 == 3'd7) begin
					o.mnemonic_code = MN_RSWD;
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i3);
				end else begin
					// INCR, DECR, COMR, NEGR, ADCR
					o.mnemonic_code = MN_SETC + 7'(i2);
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i3);
				end
			end
			4'd1: begin
				// shifts and rotates, optional shift by two
				o.mnemonic_code = MN_SWAP + 7'(i2);
				o.first_kind    = KIND_REG;
				o.first_value   = 16'(i3[1:0]);
				if (i3[2]) begin
					o.second_kind  = KIND_LIT2;
					o.second_value = 16'd2;
				end
			end
			4'd2: begin
				o.first_kind  = KIND_REG;
				o.first_value = 16'(i2);
				if (i2 == i3)
					o.mnemonic_code = MN_TSTR;
				else if (i3 == 3'd7)
					o.mnemonic_code = MN_JR;
				else begin
					o.mnemonic_code = MN_MOVR;
					o.second_kind   = KIND_REG;
					o.second_value  = 16'(i3);
				end
			end
			4'd3, 4'd4, 4'd5, 4'd6: begin
				o.mnemonic_code = MN_TSTR + 7'(i1);
				o.first_kind    = KIND_REG;
				o.first_value   = 16'(i2);
				o.second_kind   = KIND_REG;
				o.second_value  = 16'(i3);
			end
			4'd7: begin
				if (i2 == i3) begin
					o.mnemonic_code = MN_CLRR;
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i3);
				end else begin
					o.mnemonic_code = MN_XORR;
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i2);
					o.second_kind   = KIND_REG;
					o.second_value  = 16'(i3);
				end
			end
			4'd8: begin
				if (w1[4:0] == 5'h08)
					o.mnemonic_code = MN_NOPP;
				else begin
					if (w1[4:0] == 5'h00)
						o.mnemonic_code = MN_B;
					else if (!w1[4])
						o.mnemonic_code = MN_BCOND + 7'(w1[3:0]);
					else begin
						o.mnemonic_code = MN_BEXT;
						o.second_kind   = KIND_LITE;
						o.second_value  = 16'd14;
					end
					o.first_kind   = KIND_ADDR;
					o.first_value  = baddr;
					o.target_valid = 1'b1;
					o.target_addr  = baddr;
				end
			end
			4'd9: begin
				// stores: source register first
				o.first_kind  = KIND_REG;
				o.first_value = 16'(i3);
				if (i2 == 3'd0) begin
					o.mnemonic_code = MN_MVO;
					o.second_kind   = KIND_ADDR;
					o.second_value  = w2;
				end else if (i2 == 3'd6)
					o.mnemonic_code = MN_PSHR;
				else if (i2 == 3'd7) begin
					o.mnemonic_code = MN_MVOI;
					o.second_kind   = KIND_IMM;
					o.second_value  = imm;
				end else begin
					o.mnemonic_code = MN_MVO_IND;
					o.second_kind   = KIND_REG;
					o.second_value  = 16'(i2);
				end
			end
			default: begin
				// loads and ALU ops with direct, immediate or indirect source
				base = (i1 == 4'd10) ? MN_MVI : 7'(MN_ALU_BASE + 3 * (int'(i1) - 11));
				o.second_kind  = KIND_REG;
				o.second_value = 16'(i3);
				if (i1 == 4'd10 && i2 == 3'd6) begin
					o.mnemonic_code = MN_PULR;
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i3);
					o.second_kind   = KIND_NONE;
					o.second_value  = '0;
				end else if (i2 == 3'd0) begin
					o.mnemonic_code = base;
					o.first_kind    = KIND_ADDR;
					o.first_value   = w2;
				end else if (i2 == 3'd7) begin
					o.mnemonic_code = base + ((i1 == 4'd10) ? 7'd2 : 7'd1);
					o.first_kind    = KIND_IMM;
					o.first_value   = imm;
				end else begin
					o.mnemonic_code = base + ((i1 == 4'd10) ? 7'd3 : 7'd2);
					o.first_kind    = KIND_REG;
					o.first_value   = 16'(i2);
				end
			end
		endcase
		return o;
	endfunction

	// idle cycles before the next request or pop; every fourth stretch runs back to back
	function automatic int draw_gap(input int n);
		if ((n / 100) % 4 == 2)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	task automatic add_req(input logic [15:0] a, input logic d, input logic [9:0] w1,
			input logic [15:0] w2, input logic [15:0] w3);
		cpdec_req_t r;
		r.instr_addr  = a;
		r.double_byte = d;
		r.word_one    = w1;
		r.word_two    = w2;
		r.word_three  = w3;
		pending_instr_q.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [9:0] op,
			input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: opcode %h %s mismatch: expected %h, actual %h",
				$time, op, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input decode_pair_t p, input cpdec_rsp_t act);
		logic [9:0] op;
		op = p.req.word_one;
		compare_field("word_count",    op, 16'(p.rsp.word_count),    16'(act.word_count));
		compare_field("mnemonic_code", op, 16'(p.rsp.mnemonic_code), 16'(act.mnemonic_code));
		compare_field("first_kind",    op, 16'(p.rsp.first_kind),    16'(act.first_kind));
		compare_field("first_value",   op, p.rsp.first_value,        act.first_value);
		compare_field("second_kind",   op, 16'(p.rsp.second_kind),   16'(act.second_kind));
		compare_field("second_value",  op, p.rsp.second_value,       act.second_value);
		compare_field("target_addr",   op, p.rsp.target_addr,        act.target_addr);
		compare_field("target_valid",  op, 16'(p.rsp.target_valid),  16'(act.target_valid));
	endtask

	// request driver, fed from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push      <= 1'b0;
			instr     <= '0;
			send_wait = draw_gap(0);
		end else begin
			if (push && !full) begin
				expected_decode_q.push_back('{req: instr, rsp: decode_instr(instr)});
				void'(pending_instr_q.pop_front());
				sent_count++;
				send_wait = draw_gap(sent_count);
			end
			// an offered request stays put until it is taken
			if (!(push && full)) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending_instr_q.size() > 0) begin
					push  <= 1'b1;
					instr <= pending_instr_q[0];
				end else
					push <= 1'b0;
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop       <= 1'b0;
			recv_wait = draw_gap(50);
		end else begin
			if (pop && !empty) begin
				if (expected_decode_q.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, actual %h",
						$time, result);
					errors++;
				end else begin
					oldest = expected_decode_q.pop_front();
					check_result(oldest, result);
					if (oldest.rsp.target_valid)
						target_count++;
					if (oldest.req.double_byte)
						sdbd_count++;
				end
				decoded_count++;
				// long hold-offs back up both queues until full rises
				if (decoded_count == 150 || decoded_count == 600)
					recv_wait = HOLD_CYCLES;
				else
					recv_wait = draw_gap(decoded_count + 50);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, expected_decode_q.size());
				$display("cp1610_instruction_decoder_core regression: fail");
				$finish;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [15:0] pc;
		logic        prev_sdbd;
		logic [9:0]  op;
		cpdec_req_t  r;
		cpdec_rsp_t  d;
		int          sel;

		// implied-operand group, including a plain J with only the low ten address bits set
		for (int k = 0; k < 8; k++)
			add_req(16'h0000, 1'b0, 10'(k), 16'h0300, 16'h03ff);
		add_req(16'hffff, 1'b0, 10'h004, 16'h02fe, 16'hffff);  // JSR through R6
		add_req(16'h1234, 1'b1, 10'h004, 16'hffff, 16'hffff);  // J, mode bits set
		add_req(16'h0000, 1'b0, 10'h037, 16'h0000, 16'h0000);  // SIN 2
		add_req(16'h0000, 1'b0, 10'h03b, 16'h0000, 16'h0000);  // RSWD
		add_req(16'h0000, 1'b0, 10'h04c, 16'h0000, 16'h0000);  // shift by two
		add_req(16'h0000, 1'b0, 10'h0b7, 16'h0000, 16'h0000);  // JR
		add_req(16'h0000, 1'b0, 10'h1ff, 16'h0000, 16'h0000);  // CLRR
		// branches wrapping below zero and past the top
		add_req(16'h0000, 1'b0, 10'h220, 16'h0002, 16'h0000);
		add_req(16'hffff, 1'b0, 10'h201, 16'hffff, 16'hffff);
		add_req(16'h8000, 1'b0, 10'h208, 16'h1234, 16'h0000);  // NOPP has no target
		add_req(16'h0100, 1'b0, 10'h210, 16'h0010, 16'h0000);  // BEXT forward
		add_req(16'h0100, 1'b1, 10'h23f, 16'hffff, 16'h0000);  // BEXT backward
		add_req(16'h0000, 1'b0, 10'h240, 16'hffff, 16'h0000);  // MVO
		add_req(16'h0000, 1'b1, 10'h278, 16'h12ab, 16'hcdef);  // MVOI under SDBD stays 2
		add_req(16'h0000, 1'b0, 10'h2b0, 16'h0000, 16'h0000);  // PULR
		add_req(16'h0000, 1'b1, 10'h2b8, 16'hff00, 16'h00ff);  // MVII, three words
		add_req(16'h0000, 1'b0, 10'h3ff, 16'hffff, 16'hffff);  // XORI, two words
		add_req(16'hfffe, 1'b1, 10'h3f8, 16'h00ff, 16'hff00);
		directed_count = pending_instr_q.size();

		// random stream: running address, SDBD mostly followed by an immediate form
		pc        = 16'($urandom);
		prev_sdbd = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (prev_sdbd && sel < 80)
				op = {4'($urandom_range(9, 15)), 3'b111, 3'($urandom)};
			else if (sel < 15)
				op = 10'h001;
			else if (sel < 25)
				op = 10'h004;
			else if (sel < 40)
				op = {4'h8, 6'($urandom)};
			else
				op = 10'($urandom);
			r.instr_addr  = pc;
			r.double_byte = prev_sdbd;
			// noise: stray SDBD flags and jumps in the address stream
			if ($urandom_range(0, 19) == 0)
				r.double_byte = ~r.double_byte;
			if ($urandom_range(0, 19) == 0)
				r.instr_addr = 16'($urandom);
			r.word_one   = op;
			r.word_two   = 16'($urandom);
			r.word_three = 16'($urandom);
			pending_instr_q.push_back(r);
			d         = decode_instr(r);
			pc        = r.instr_addr + 16'(d.word_count);
			prev_sdbd = (op == 10'h001);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_instr_q.size() != 0 || expected_decode_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("decoded %0d instructions (%0d directed), %0d under SDBD, %0d with targets",
			decoded_count, directed_count, sdbd_count, target_count);
		$display("random idling on both sides, two long result stalls to back up the input");
		if (errors == 0)
			$display("cp1610_instruction_decoder_core regression: pass");
		else
			$display("cp1610_instruction_decoder_core regression: fail");
		$finish;
	end

endmodule
